[rtl/ogrc_pkg.sv]
// ----------------------------------------------------------------------------
// ogrc_pkg
// Shared types and constants of the occupancy grid ray caster.
// ----------------------------------------------------------------------------
package ogrc_pkg;

  localparam int unsigned MaxWidth   = 256;
  localparam int unsigned MaxHeight  = 256;
  localparam int unsigned XW         = $clog2(MaxWidth);
  localparam int unsigned YW         = $clog2(MaxHeight);
  localparam int unsigned CellCount  = MaxWidth * MaxHeight;
  localparam int unsigned AddrW      = XW + YW;
  localparam int unsigned CordicSteps = 14;
  localparam int unsigned CordicStart = 9949;

  // position width: 24 bit pose times 16 bit scale times 64, plus march headroom
  localparam int unsigned PosW = 52;

  // register indexes
  localparam logic [2:0] RegGridWidth  = 3'd0;
  localparam logic [2:0] RegGridHeight = 3'd1;
  localparam logic [2:0] RegMaxRange   = 3'd2;
  localparam logic [2:0] RegMapScale   = 3'd3;
  localparam logic [2:0] RegStepSize   = 3'd4;

  // status codes
  localparam logic [1:0] StHit     = 2'd0;
  localparam logic [1:0] StMax     = 2'd1;
  localparam logic [1:0] StLeft    = 2'd2;
  localparam logic [1:0] StBadPose = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic        occupied;
    logic [23:0] pose_x;
    logic [23:0] pose_y;
    logic [15:0] pose_heading;
    logic [15:0] beam_angle;
    logic        last_beam;
  } in_item_t;

  typedef struct packed {
    logic [23:0] beam_range;
    logic [1:0]  status;
    logic        scan_end;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [23:0] data;
  } cfg_item_t;

  // arctangent table, binary angle units
  function automatic logic [13:0] atan_lut(input logic [3:0] i);
    case (i)
      4'd0:  atan_lut = 14'd8192;
      4'd1:  atan_lut = 14'd4836;
      4'd2:  atan_lut = 14'd2555;
      4'd3:  atan_lut = 14'd1297;
      4'd4:  atan_lut = 14'd651;
      4'd5:  atan_lut = 14'd326;
      4'd6:  atan_lut = 14'd163;
      4'd7:  atan_lut = 14'd81;
      4'd8:  atan_lut = 14'd41;
      4'd9:  atan_lut = 14'd20;
      4'd10: atan_lut = 14'd10;
      4'd11: atan_lut = 14'd5;
      4'd12: atan_lut = 14'd3;
      4'd13: atan_lut = 14'd1;
      default: atan_lut = 14'd0;
    endcase
  endfunction

endpackage

[rtl/ogrc_if.sv]
// ----------------------------------------------------------------------------
// ogrc_in_if / ogrc_out_if / ogrc_cfg_if
// Valid/ready channels of the ray caster.
// ----------------------------------------------------------------------------
interface ogrc_in_if;
  import ogrc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ogrc_out_if;
  import ogrc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ogrc_cfg_if;
  import ogrc_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/occupancy_grid_ray_caster.sv]
// ----------------------------------------------------------------------------
// occupancy_grid_ray_caster
// Marches a ray through a one-bit occupancy grid and returns the range.
//
// channel  dir  payload
// in_ch    in   kind, cell write, pose, beam angle, last_beam
// out_ch   out  beam_range, status, scan_end
// cfg_ch   in   register index, write data
//
// A grid write is done in S_IDLE. A cast sets up with 2 pose products, pose
// cell check, pose cell read, 14 CORDIC iterations on one shared adder pair,
// 2 step products and range limit, then marches in steps of S_CHKSTEP,
// S_MOVE, S_READ and S_TEST (one grid RAM read each), runs a restoring divide
// on a hit and loads the output register. The grid RAM port sets the march
// rate. The grid is not cleared at reset. Items are taken while a result
// waits; a finished cast holds in S_OUT until the output register is free.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_caster (
  input  logic clk_i,
  input  logic rst_ni,
  ogrc_in_if.sink    in_ch,
  ogrc_out_if.source out_ch,
  ogrc_cfg_if.sink   cfg_ch
);
  import ogrc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_POSECHK, S_POSERD, S_CORDIC, S_STEPMUL,
    S_LIMIT, S_CHKSTEP, S_MOVE, S_READ, S_TEST, S_DIV, S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [8:0]  gw_q, gh_q;
  logic [23:0] maxr_q;
  logic [15:0] scale_q;
  logic [7:0]  step_q;

  // working registers
  in_item_t          item_q;
  logic signed [PosW-1:0] px_q, py_q, dx_q, dy_q;
  logic signed [17:0] cx_q, cy_q, z_q;
  logic               flip_q, ysel_q;
  logic [3:0]         it_q;
  logic [47:0]        limit_q, dist_q;
  logic [15:0]        rem_q;
  logic [24:0]        quo_q;
  logic [4:0]         dcnt_q;
  out_item_t          rslt_q;
  out_item_t          res_q;
  logic               out_valid_q;

  // effective settings
  logic [8:0]  gw_eff, gh_eff;
  logic [15:0] scale_eff;
  logic [7:0]  step_eff;
  assign gw_eff    = (gw_q == 9'd0) ? 9'd0 : (gw_q > 9'(MaxWidth)) ? 9'(MaxWidth) : gw_q;
  assign gh_eff    = (gh_q == 9'd0) ? 9'd0 : (gh_q > 9'(MaxHeight)) ? 9'(MaxHeight) : gh_q;
  assign scale_eff = (scale_q == 16'd0) ? 16'd1 : scale_q;
  assign step_eff  = (step_q == 8'd0) ? 8'd1 : step_q;

  // cell of a Q.22 coordinate: ceiling
  localparam logic signed [PosW-1:0] OneM1 = PosW'((64'd1 << 22) - 64'd1);
  logic signed [PosW-1:0] cxs, cys;
  logic signed [17:0] cx_new, cy_new;
  assign cxs    = (px_q + OneM1) >>> 22;
  assign cys    = (py_q + OneM1) >>> 22;
  assign cx_new = 18'(cxs);
  assign cy_new = 18'(cys);

  logic in_grid;
  logic cx_hi_ok, cy_hi_ok;
  assign cx_hi_ok = (cxs < $signed({{(PosW-10){1'b0}}, 1'b0, gw_eff}));
  assign cy_hi_ok = (cys < $signed({{(PosW-10){1'b0}}, 1'b0, gh_eff}));
  assign in_grid  = !cxs[PosW-1] && !cys[PosW-1] && cx_hi_ok && cy_hi_ok;

  // grid ram
  logic             ram_we, ram_rd;
  logic [AddrW-1:0] ram_addr;
  logic [0:0]       ram_rdata;
  assign ram_we = (state_q == S_IDLE) && in_ch.valid && in_ch.ready && !in_ch.data.kind
                  && ({24'd0, in_ch.data.cell_x} < 32'(MaxWidth))
                  && ({24'd0, in_ch.data.cell_y} < 32'(MaxHeight));
  assign ram_addr = (state_q == S_IDLE)
                  ? {in_ch.data.cell_y[YW-1:0], in_ch.data.cell_x[XW-1:0]}
                  : {cy_q[YW-1:0], cx_q[XW-1:0]};
  assign ram_rd = ram_rdata[0];

  ogrc_ram #(.Width(1), .Depth(CellCount)) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_ch.data.occupied),
    .rdata_o (ram_rdata)
  );

  // shared multiplier: 24x16 pose scaling, 8x16 step products or 24x16 range limit
  logic signed [24:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [41:0] mul_p;
  always_comb begin
    mul_a = 25'sd0;
    mul_b = 17'sd0;
    unique case (state_q)
      S_SCALE: begin
        mul_a = {item_q.pose_x[23], ysel_q ? item_q.pose_y : item_q.pose_x};
        mul_b = {1'b0, scale_eff};
      end
      S_STEPMUL: begin
        mul_a = {17'd0, step_eff};
        mul_b = ysel_q ? 17'(dy_q) : 17'(dx_q);
      end
      S_LIMIT: begin
        mul_a = {1'b0, maxr_q};
        mul_b = {1'b0, scale_eff};
      end
      default: ;
    endcase
    if (state_q == S_SCALE && ysel_q) mul_a = {item_q.pose_y[23], item_q.pose_y};
  end
  assign mul_p = mul_a * mul_b;

  // cordic shared add/subtract unit
  logic signed [17:0] csx, csy, nx, ny;
  assign csx = 18'(dx_q) >>> it_q;
  assign csy = 18'(dy_q) >>> it_q;
  assign nx  = z_q[17] ? 18'(dx_q) + csy : 18'(dx_q) - csy;
  assign ny  = z_q[17] ? 18'(dy_q) - csx : 18'(dy_q) + csx;

  logic [16:0] ang;
  logic signed [17:0] zs;
  assign ang = {1'b0, item_q.pose_heading} + {1'b0, item_q.beam_angle};
  assign zs  = {{2{ang[15]}}, ang[15:0]};

  logic [47:0] dist_next;
  assign dist_next = dist_q + {32'd0, step_eff, 8'd0};

  // restoring divide step: remainder stays below the scale
  logic [16:0] div_sh;
  logic [17:0] sub_try;
  logic        q_bit;
  logic [24:0] quo_next;
  assign div_sh   = {rem_q, quo_q[24]};
  assign sub_try  = {1'b0, div_sh} - {2'b00, scale_eff};
  assign q_bit    = !sub_try[17];
  assign quo_next = {quo_q[23:0], q_bit};

  // output register loads when empty or emptying
  logic res_load;
  assign res_load = (state_q == S_OUT) && (!out_valid_q || out_ch.ready);

  assign in_ch.ready  = (state_q == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = res_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      gw_q        <= 9'd256;
      gh_q        <= 9'd256;
      maxr_q      <= 24'd1280;
      scale_q     <= 16'd256;
      step_q      <= 8'd128;
      item_q      <= '0;
      px_q        <= '0;
      py_q        <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      z_q         <= '0;
      flip_q      <= 1'b0;
      ysel_q      <= 1'b0;
      it_q        <= '0;
      limit_q     <= '0;
      dist_q      <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      dcnt_q      <= '0;
      rslt_q      <= '0;
      res_q       <= '0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.data.index)
          RegGridWidth:  gw_q    <= cfg_ch.data.data[8:0];
          RegGridHeight: gh_q    <= cfg_ch.data.data[8:0];
          RegMaxRange:   maxr_q  <= cfg_ch.data.data;
          RegMapScale:   scale_q <= cfg_ch.data.data[15:0];
          RegStepSize:   step_q  <= cfg_ch.data.data[7:0];
          default: ;
        endcase
      end
      if (res_load) begin
        res_q       <= rslt_q;
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_ch.valid && in_ch.data.kind) begin
            item_q  <= in_ch.data;
            ysel_q  <= 1'b0;
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (ysel_q) begin
            py_q    <= PosW'(mul_p) <<< 6;
            state_q <= S_POSECHK;
          end else begin
            px_q <= PosW'(mul_p) <<< 6;
          end
          ysel_q <= !ysel_q;
        end
        S_POSECHK: begin
          cx_q <= cx_new;
          cy_q <= cy_new;
          if (!in_grid) begin
            rslt_q  <= '{beam_range: 24'd0, status: StBadPose, scan_end: item_q.last_beam};
            state_q <= S_OUT;
          end else begin
            state_q <= S_POSERD;
            it_q    <= 4'd0;
          end
        end
        S_POSERD: begin
          // ram address presented from cx/cy this cycle, data next
          if (it_q == 4'd1) begin
            if (ram_rd) begin
              rslt_q  <= '{beam_range: 24'd0, status: StBadPose, scan_end: item_q.last_beam};
              state_q <= S_OUT;
            end else begin
              dx_q    <= PosW'(CordicStart);
              dy_q    <= '0;
              flip_q  <= (zs > 18'sd16384) || (zs < -18'sd16384);
              z_q     <= (zs > 18'sd16384) ? zs - 18'sd32768
                       : (zs < -18'sd16384) ? zs + 18'sd32768 : zs;
              it_q    <= 4'd0;
              state_q <= S_CORDIC;
            end
          end else begin
            it_q <= it_q + 4'd1;
          end
        end
        S_CORDIC: begin
          dx_q <= PosW'(nx);
          dy_q <= PosW'(ny);
          z_q  <= z_q[17] ? z_q + 18'($signed({1'b0, atan_lut(it_q)}))
                          : z_q - 18'($signed({1'b0, atan_lut(it_q)}));
          if (it_q == 4'(CordicSteps - 1)) begin
            ysel_q  <= 1'b0;
            state_q <= S_STEPMUL;
          end
          it_q <= it_q + 4'd1;
        end
        S_STEPMUL: begin
          if (!ysel_q) begin
            dx_q <= flip_q ? -PosW'(mul_p) : PosW'(mul_p);
          end else begin
            dy_q    <= flip_q ? -PosW'(mul_p) : PosW'(mul_p);
            state_q <= S_LIMIT;
          end
          ysel_q <= !ysel_q;
        end
        S_LIMIT: begin
          limit_q <= 48'(unsigned'(mul_p[40:0]));
          dist_q  <= '0;
          state_q <= S_CHKSTEP;
        end
        S_CHKSTEP: begin
          dist_q <= dist_next;
          if (dist_next > limit_q) begin
            rslt_q  <= '{beam_range: maxr_q, status: StMax, scan_end: item_q.last_beam};
            state_q <= S_OUT;
          end else begin
            px_q    <= px_q + dx_q;
            py_q    <= py_q + dy_q;
            state_q <= S_MOVE;
          end
        end
        S_MOVE: begin
          cx_q <= cx_new;
          cy_q <= cy_new;
          if (!in_grid) begin
            rslt_q  <= '{beam_range: maxr_q, status: StLeft, scan_end: item_q.last_beam};
            state_q <= S_OUT;
          end else begin
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_TEST;
        S_TEST: begin
          if (ram_rd) begin
            // high part at or above the scale means a quotient past 25 bits
            if (dist_q[47:25] >= {7'd0, scale_eff}) begin
              rslt_q  <= '{beam_range: 24'hFFFFFF, status: StHit,
                           scan_end: item_q.last_beam};
              state_q <= S_OUT;
            end else begin
              rem_q   <= dist_q[40:25];
              quo_q   <= dist_q[24:0];
              dcnt_q  <= 5'd0;
              state_q <= S_DIV;
            end
          end else begin
            state_q <= S_CHKSTEP;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle over the low 25 bits
          rem_q  <= q_bit ? sub_try[15:0] : div_sh[15:0];
          quo_q  <= quo_next;
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'd24) begin
            rslt_q  <= '{beam_range: quo_next[24] ? 24'hFFFFFF : quo_next[23:0],
                         status: StHit, scan_end: item_q.last_beam};
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/ogrc_ram.sv]
// ----------------------------------------------------------------------------
// ogrc_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module ogrc_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // read before write, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
